// ===== rtl/core/mcs_pkg.sv =====
`timescale 1ns / 1ps

package mcs_pkg;

   localparam int RAW_W     = 16;
   localparam int MOVE_W    = 17;
   localparam int SENS_W    = 8;
   localparam int CARRY_W   = 9;
   localparam int SUM_W     = 18;
   localparam int MAG_W     = 16;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [SUM_W-1:0] FOLD_LIMIT = 18'sd32768;
   localparam logic signed [SUM_W-1:0] FOLD_SPAN  = 18'sd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SENSITIVITY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_Y   = 3'd3;

   typedef enum logic [1:0] {
      MODE_NONE      = 2'd0,
      MODE_X_SPINNER = 2'd1,
      MODE_Y_SPINNER = 2'd2,
      MODE_TRACKBALL = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [SENS_W-1:0] sensitivity;
      logic              reverse_x;
      logic              reverse_y;
   } cfg_type;

   typedef struct packed {
      logic start;   // capture beat, fold sums, load divider
      logic step;    // one restoring division step, both axes
      logic finish;  // form result, update carries, load output register
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/mcs_ctrl.sv =====
`timescale 1ns / 1ps

module mcs_ctrl
   import mcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = CNT_W'(DIV_STEPS - 1);
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/mcs_datapath.sv =====
`timescale 1ns / 1ps

module mcs_datapath
   import mcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [RAW_W-1:0]         req_raw_dx,
   input  logic [RAW_W-1:0]         req_raw_dy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [MOVE_W-1:0] rsp_move_x,
   output logic signed [MOVE_W-1:0] rsp_move_y
);

   logic signed [CARRY_W-1:0] carry_x_ff, carry_x_in;
   logic signed [CARRY_W-1:0] carry_y_ff, carry_y_in;
   logic [MAG_W-1:0]          quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [SENS_W-1:0]         rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic                      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic                      valid_ff, valid_in;
   logic signed [MOVE_W-1:0]  move_x_ff, move_x_in, move_y_ff, move_y_in;

   logic [SENS_W-1:0]         divisor;
   logic [MAG_W-1:0]          mag_x, mag_y;
   logic                      sgn_x, sgn_y;
   logic [MAG_W-1:0]          nq_x, nq_y;
   logic [SENS_W-1:0]         nr_x, nr_y;
   logic signed [MOVE_W-1:0]  qx, qy, mx, my;

   // sensitivity zero behaves as one
   assign divisor = (cfg.sensitivity == '0) ? SENS_W'(1) : cfg.sensitivity;

   function automatic logic [MAG_W:0] fold_mag(input logic signed [CARRY_W-1:0] carry,
                                               input logic [RAW_W-1:0] raw);
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] mag;
      sum = SUM_W'(carry) + $signed({2'b00, raw});
      if (sum > FOLD_LIMIT) begin
         sum = sum - FOLD_SPAN;
      end
      mag = sum[SUM_W-1] ? -sum : sum;
      return {sum[SUM_W-1], mag[MAG_W-1:0]};
   endfunction

   // one restoring step; remainder stays below divisor so 8 bits suffice
   function automatic logic [MAG_W+SENS_W-1:0] div_step(input logic [MAG_W-1:0] quo,
                                                        input logic [SENS_W-1:0] rem,
                                                        input logic [SENS_W-1:0] dv);
      logic [SENS_W:0] trial;
      logic [SENS_W:0] diff;
      trial = {rem, quo[MAG_W-1]};
      diff  = trial - {1'b0, dv};
      if (trial >= {1'b0, dv}) begin
         return {quo[MAG_W-2:0], 1'b1, diff[SENS_W-1:0]};
      end
      return {quo[MAG_W-2:0], 1'b0, trial[SENS_W-1:0]};
   endfunction

   always_comb begin
      {sgn_x, mag_x} = fold_mag(carry_x_ff, req_raw_dx);
      {sgn_y, mag_y} = fold_mag(carry_y_ff, req_raw_dy);
      {nq_x, nr_x}   = div_step(quo_x_ff, rem_x_ff, divisor);
      {nq_y, nr_y}   = div_step(quo_y_ff, rem_y_ff, divisor);

      qx = neg_x_ff ? -$signed({1'b0, quo_x_ff}) : $signed({1'b0, quo_x_ff});
      qy = neg_y_ff ? -$signed({1'b0, quo_y_ff}) : $signed({1'b0, quo_y_ff});

      mx = '0;
      my = '0;
      case (cfg.mode)
         MODE_NONE:      begin mx = '0; my = '0; end
         MODE_X_SPINNER: begin mx = qx; my = '0; end
         MODE_Y_SPINNER: begin mx = qy; my = '0; end
         MODE_TRACKBALL: begin mx = qx; my = qy; end
         default:        begin mx = '0; my = '0; end
      endcase
      if (cfg.reverse_x) mx = -mx;
      if (cfg.reverse_y) my = -my;

      quo_x_in   = quo_x_ff;
      quo_y_in   = quo_y_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      carry_x_in = carry_x_ff;
      carry_y_in = carry_y_ff;
      move_x_in  = move_x_ff;
      move_y_in  = move_y_ff;
      valid_in   = valid_ff & ~rsp_ready;

      if (cmd.start) begin
         quo_x_in = mag_x;
         quo_y_in = mag_y;
         rem_x_in = '0;
         rem_y_in = '0;
         neg_x_in = sgn_x;
         neg_y_in = sgn_y;
      end
      if (cmd.step) begin
         quo_x_in = nq_x;
         quo_y_in = nq_y;
         rem_x_in = nr_x;
         rem_y_in = nr_y;
      end
      if (cmd.finish) begin
         // remainder takes the sign of the dividend
         if (cfg.mode == MODE_NONE) begin
            carry_x_in = '0;
            carry_y_in = '0;
         end else begin
            carry_x_in = neg_x_ff ? -$signed({1'b0, rem_x_ff}) : $signed({1'b0, rem_x_ff});
            carry_y_in = neg_y_ff ? -$signed({1'b0, rem_y_ff}) : $signed({1'b0, rem_y_ff});
         end
         move_x_in = mx;
         move_y_in = my;
         valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_x_ff <= '0;
         carry_y_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         carry_x_ff <= carry_x_in;
         carry_y_ff <= carry_y_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_x_ff  <= quo_x_in;
      quo_y_ff  <= quo_y_in;
      rem_x_ff  <= rem_x_in;
      rem_y_ff  <= rem_y_in;
      neg_x_ff  <= neg_x_in;
      neg_y_ff  <= neg_y_in;
      move_x_ff <= move_x_in;
      move_y_ff <= move_y_in;
   end

   assign status.out_free = ~valid_ff | rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_move_x      = move_x_ff;
   assign rsp_move_y      = move_y_ff;

endmodule

// ===== rtl/core/motion_count_scaler.sv =====
`timescale 1ns / 1ps
// A req beat is taken only in idle (capture); the 16-step restoring divider per axis
// then runs, and finish loads the output register once it is free. No new beat is
// taken before finish, so the divider sets the throughput unless the output stalls.
// A finished result waits in the output register; the next req beat is taken meanwhile.
// Reset (synchronous, active high): idle, no result pending, carries zero,
// mode none, sensitivity 1, both reverse flags clear.

module motion_count_scaler
   import mcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RAW_W-1:0]         req_raw_dx,
   input  logic [RAW_W-1:0]         req_raw_dy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [MOVE_W-1:0] rsp_move_x,
   output logic signed [MOVE_W-1:0] rsp_move_y,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SENS_W-1:0]        csr_data
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // config writes are registered; unknown indexes are dropped,
   // upper data bits beyond a field's width are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DEVICE_MODE: cfg_in.mode        = mode_type'(csr_data[1:0]);
            REG_SENSITIVITY: cfg_in.sensitivity = csr_data;
            REG_REVERSE_X:   cfg_in.reverse_x   = csr_data[0];
            REG_REVERSE_Y:   cfg_in.reverse_y   = csr_data[0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_NONE;
         cfg_ff.sensitivity <= SENS_W'(1);
         cfg_ff.reverse_x   <= 1'b0;
         cfg_ff.reverse_y   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: idle -> 16 divide steps -> finish when output register frees
   mcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // fold, two restoring dividers, mode select, carries, output register
   mcs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .req_raw_dx (req_raw_dx),
      .req_raw_dy (req_raw_dy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_move_x (rsp_move_x),
      .rsp_move_y (rsp_move_y)
   );

endmodule

// ===== rtl/core/mcs_checker.sv =====
`timescale 1ns / 1ps

module mcs_checker
   import mcs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [MOVE_W-1:0] rsp_move_x,
   input logic signed [MOVE_W-1:0] rsp_move_y
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // one beat in flight: no back-to-back acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req accepted while busy");

   // a result never appears the cycle after its beat
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result too early");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_move_x) && $stable(rsp_move_y)))
      else $error("stalled rsp beat changed");

endmodule

bind motion_count_scaler mcs_checker u_mcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_move_x (rsp_move_x),
   .rsp_move_y (rsp_move_y)
);

// ===== test/tb_motion_count_scaler.sv =====
`timescale 1ns / 1ps

module tb_motion_count_scaler;
   import mcs_pkg::*;

   // One raw counter pair as it goes into the block.
   typedef struct packed {
      logic [RAW_W-1:0] dx;
      logic [RAW_W-1:0] dy;
   } raw_pair_type;

   // One scaled movement pair as it leaves the block.
   typedef struct {
      logic signed [MOVE_W-1:0] move_x;
      logic signed [MOVE_W-1:0] move_y;
   } move_pair_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [RAW_W-1:0]         req_raw_dx = '0;
   logic [RAW_W-1:0]         req_raw_dy = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [MOVE_W-1:0] rsp_move_x;
   logic signed [MOVE_W-1:0] rsp_move_y;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [SENS_W-1:0]        csr_data = '0;

   motion_count_scaler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_raw_dx (req_raw_dx),
      .req_raw_dy (req_raw_dy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_move_x (rsp_move_x),
      .rsp_move_y (rsp_move_y),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // Pending req beats (filled by the sequence below) and the movements
   // that accepted beats are owed, oldest first.
   raw_pair_type   raw_queue[$];
   move_pair_type  move_owed[$];
   int unsigned    fail_count = 0;

   // Idling on/off for the current phase; off gives back-to-back stretches.
   bit idle_on = 1'b1;

   // Shadow of the block's settings and its two kept remainders.
   cfg_type cfg_shadow;
   int      rem_x;
   int      rem_y;

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 50)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 20);
      return $urandom_range(21, 60);
   endfunction

   // Add a reading to a remainder, fold sums above 32768 down by 65536,
   // divide truncating toward zero; remainder goes back out.
   function automatic int fold_divide(input int rem_in, input logic [RAW_W-1:0] raw,
                                      input int divisor, output int rem_out);
      int sum;
      sum = rem_in + int'(raw);
      if (sum > int'(FOLD_LIMIT))
         sum = sum - int'(FOLD_SPAN);
      rem_out = sum % divisor;
      return sum / divisor;
   endfunction

   // Expected movement for one accepted beat; updates the remainders.
   function automatic move_pair_type predict_move(input raw_pair_type raw);
      move_pair_type res;
      int divisor;
      int qx;
      int qy;
      int mx;
      int my;
      // a zero divisor behaves as one
      divisor = (cfg_shadow.sensitivity == '0) ? 1 : int'(cfg_shadow.sensitivity);
      qx = fold_divide(rem_x, raw.dx, divisor, rem_x);
      qy = fold_divide(rem_y, raw.dy, divisor, rem_y);
      mx = qx;
      my = qy;
      case (cfg_shadow.mode)
         MODE_NONE: begin
            // nothing reported, remainders dropped
            mx = 0;
            my = 0;
            rem_x = 0;
            rem_y = 0;
         end
         MODE_X_SPINNER: my = 0;
         MODE_Y_SPINNER: begin
            // Y motion is reported on the X output
            mx = qy;
            my = 0;
         end
         default: ;
      endcase
      if (cfg_shadow.mode != MODE_NONE) begin
         if (cfg_shadow.reverse_x)
            mx = -mx;
         if (cfg_shadow.reverse_y)
            my = -my;
      end
      res.move_x = mx[MOVE_W-1:0];
      res.move_y = my[MOVE_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------
   // req driver: one beat from raw_queue at a time, random gap after
   // each accepted beat. valid holds with a stable payload until taken.
   // ---------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      raw_pair_type next_raw;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && !req_ready)) begin
         // previous beat taken (or none offered): decide on the next one
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (raw_queue.size() > 0) begin
            next_raw = raw_queue.pop_front();
            req_valid  <= 1'b1;
            req_raw_dx <= next_raw.dx;
            req_raw_dy <= next_raw.dy;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp back-pressure: ready drops for random stretches
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------
   // Monitor: tracks register writes, predicts on each req beat and
   // checks each rsp beat against the oldest owed movement. The rsp
   // check runs before the prediction so a stray beat is never matched
   // against a req taken on the same edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      move_pair_type want;
      if (reset) begin
         cfg_shadow.mode        = MODE_NONE;
         cfg_shadow.sensitivity = SENS_W'(1);
         cfg_shadow.reverse_x   = 1'b0;
         cfg_shadow.reverse_y   = 1'b0;
         rem_x = 0;
         rem_y = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            // bits above a register's width are dropped, unused indexes ignored
            case (csr_index)
               REG_DEVICE_MODE: cfg_shadow.mode        = mode_type'(csr_data[1:0]);
               REG_SENSITIVITY: cfg_shadow.sensitivity = csr_data;
               REG_REVERSE_X:   cfg_shadow.reverse_x   = csr_data[0];
               REG_REVERSE_Y:   cfg_shadow.reverse_y   = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (move_owed.size() == 0) begin
               $error("rsp beat with nothing owed: move_x %0d move_y %0d",
                      rsp_move_x, rsp_move_y);
               fail_count++;
            end else begin
               want = move_owed.pop_front();
               if (rsp_move_x !== want.move_x) begin
                  $error("move_x: expected %0d, got %0d", want.move_x, rsp_move_x);
                  fail_count++;
               end
               if (rsp_move_y !== want.move_y) begin
                  $error("move_y: expected %0d, got %0d", want.move_y, rsp_move_y);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            move_owed.push_back(predict_move('{dx: req_raw_dx, dy: req_raw_dy}));
      end
   end

   // ---------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------
   task automatic send(input logic [RAW_W-1:0] dx, input logic [RAW_W-1:0] dy);
      raw_queue.push_back('{dx: dx, dy: dy});
   endtask

   // One register write; only called with the block idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SENS_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Sender holds off until every owed movement has come back, then a
   // short settle before any register write.
   task automatic drain();
      do
         @(negedge clock);
      while (raw_queue.size() != 0 || req_valid || move_owed.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Half uniform readings, plus small signed motion and fold-edge values.
   function automatic logic [RAW_W-1:0] pick_raw();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return RAW_W'($urandom_range(0, 65535));
      if (r < 8)
         return RAW_W'(int'($urandom_range(0, 400)) - 200);
      return RAW_W'(32768 + int'($urandom_range(0, 8)) - 4);
   endfunction

   // New settings for a random phase; upper data bits are junk on purpose.
   task automatic shuffle_settings(input bit write_all);
      logic [1:0]        mode_bits;
      logic [SENS_W-1:0] sens;
      int unsigned       pick;
      if (write_all || $urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, 9);
         mode_bits = (pick == 0) ? MODE_NONE :
                     (pick < 3)  ? MODE_X_SPINNER :
                     (pick < 5)  ? MODE_Y_SPINNER : MODE_TRACKBALL;
         write_reg(REG_DEVICE_MODE, {6'($urandom), mode_bits});
      end
      if (write_all || $urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, 19);
         if (pick < 2)
            sens = SENS_W'(1);
         else if (pick < 4)
            sens = SENS_W'(255);
         else if (pick == 4)
            sens = '0;
         else if (pick < 12)
            sens = SENS_W'($urandom_range(2, 16));
         else
            sens = SENS_W'($urandom_range(1, 255));
         write_reg(REG_SENSITIVITY, sens);
      end
      if (write_all || $urandom_range(0, 3) != 0)
         write_reg(REG_REVERSE_X, SENS_W'($urandom));
      if (write_all || $urandom_range(0, 3) != 0)
         write_reg(REG_REVERSE_Y, SENS_W'($urandom));
      if ($urandom_range(0, 6) == 0)
         write_reg(CSR_IDX_W'(int'(REG_REVERSE_Y) + 1 + $urandom_range(0, 3)),
                   SENS_W'($urandom));
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int unsigned sent;
      int unsigned count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset settings: mode none, everything reads zero
      send(16'h0000, 16'h0000);
      send(16'hFFFF, 16'hFFFF);
      drain();

      // trackball through junk upper bits, divide by one: fold edges
      write_reg(REG_DEVICE_MODE, 8'hFF);
      send(16'h8000, 16'h8001);   // 32768 stays, 32769 folds negative
      send(16'h7FFF, 16'hFFFF);
      send(16'h0001, 16'h0000);
      drain();

      // largest divisor, both axes reversed: remainders build up
      write_reg(REG_SENSITIVITY, 8'd255);
      write_reg(REG_REVERSE_X, 8'h01);
      write_reg(REG_REVERSE_Y, 8'h03);
      send(16'hFFFF, 16'h0001);
      send(16'h00FE, 16'hFF02);
      send(16'h8000, 16'h8000);
      send(16'h7FFF, 16'h8001);
      send(16'h0100, 16'hFF00);
      drain();

      // zero divisor acts as one; X spinner drops Y
      write_reg(REG_SENSITIVITY, 8'd0);
      write_reg(REG_DEVICE_MODE, 8'd1);
      send(16'h1234, 16'hABCD);
      send(16'h8000, 16'h7FFF);
      drain();

      // Y spinner: Y quotient shows on X, with reverse_x off and reverse_y on
      write_reg(REG_DEVICE_MODE, 8'd2);
      write_reg(REG_SENSITIVITY, 8'd7);
      write_reg(REG_REVERSE_X, 8'hFE);
      write_reg(REG_REVERSE_Y, 8'h01);
      send(16'h000A, 16'hFFF3);
      send(16'h0005, 16'h0010);
      send(16'hFFFF, 16'h8000);
      drain();

      // mode none clears the remainders left above
      write_reg(REG_DEVICE_MODE, 8'hFC);
      send(16'h0003, 16'h0005);
      drain();

      // back to trackball, unused index must not disturb anything
      write_reg(REG_DEVICE_MODE, 8'd3);
      write_reg(REG_REVERSE_X, 8'd1);
      write_reg(CSR_IDX_W'(int'(REG_REVERSE_Y) + 1 + $urandom_range(0, 3)), 8'hFF);
      send(16'h0006, 16'hFFFA);
      send(16'h0001, 16'h0001);
      drain();

      // --- random phases ---
      sent = 0;
      while (sent < 1800) begin
         shuffle_settings(sent == 0);
         idle_on = ($urandom_range(0, 3) != 0);
         count = $urandom_range(10, 120);
         repeat (count) send(pick_raw(), pick_raw());
         sent += count;
         drain();
      end

      // every owed movement is back; anything arriving now is a stray beat
      repeat (40) @(posedge clock);
      if (move_owed.size() != 0) begin
         $error("%0d owed movements never arrived", move_owed.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb_motion_count_scaler: PASS");
      else
         $display("tb_motion_count_scaler: FAIL");
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #20ms;
      $display("tb_motion_count_scaler: FAIL");
      $finish;
   end

endmodule
